[hw/rtl/ascending_sort_engine_top_defines.svh]
`ifndef ASCENDING_SORT_ENGINE_TOP_DEFINES_SVH
`define ASCENDING_SORT_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ASE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ASE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ase_pkg.sv]
package ase_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WAIT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
  } elem_t;

endpackage

[hw/rtl/ase_cell.sv]
module ase_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  ase_pkg::elem_t ins,
  input  ase_pkg::elem_t nbr,
  output ase_pkg::elem_t held,
  output ase_pkg::elem_t pass
);
  import ase_pkg::*;

  elem_t held_r, held_nxt;
  elem_t pass_r, pass_nxt;

  // on shift take the neighbour's value; else keep the smaller value, hand the larger one down the chain
  always_comb begin
    held_nxt       = held_r;
    pass_nxt.valid = 1'b0;
    pass_nxt.value = ins.value;
    priority if (shift_en) begin
      held_nxt = nbr;
    end else if (ins.valid) begin
      priority if (!held_r.valid) begin
        held_nxt = ins;
      end else if (ins.value < held_r.value) begin
        held_nxt = ins;
        pass_nxt = held_r;
      end else begin
        pass_nxt = ins;
      end
    end else begin
      held_nxt = held_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      pass_r <= '0;
    end else begin
      held_r <= held_nxt;
      pass_r <= pass_nxt;
    end
  end

  assign held = held_r;
  assign pass = pass_r;

endmodule

[hw/rtl/ascending_sort_engine_top.sv]
// Loading: one value per cycle while busy is low; values that do not end a set give no result.
// After the value that ends the set is taken, busy stays high while the insertion wave crosses
// the chain of DEPTH cells in the settle state; the first result then appears on the ports.
// Results then come one per cycle, N results for a set of N stored values (N <= DEPTH).
// Synchronous active-low reset empties the chain, clears count and overflow flag; no sweep.
`include "ascending_sort_engine_top_defines.svh"
module ascending_sort_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_sample_value,
  input  logic        in_end_of_set,
  output logic        out_valid,
  output logic [31:0] out_sorted_value,
  output logic        out_final_result,
  output logic        out_overflowed
);
  import ase_pkg::*;

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_SETTLE = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  logic              ovf_r, ovf_nxt;
  elem_t             in_r, in_nxt;
  logic              accept;
  logic              shift_en;

  elem_t held [DEPTH];
  elem_t pass [DEPTH];

  assign busy     = (state_r != ST_LOAD);
  assign accept   = start && !busy;
  assign shift_en = (state_r == ST_DRAIN);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    wait_nxt     = wait_r;
    ovf_nxt      = ovf_r;
    in_nxt.valid = 1'b0;
    in_nxt.value = in_sample_value;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (cnt_r < CNT_W'(DEPTH)) begin
            in_nxt.valid = 1'b1;
            cnt_nxt      = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_end_of_set) begin
            state_nxt = ST_SETTLE;
            wait_nxt  = WAIT_W'(DEPTH);
          end
        end
      end
      ST_SETTLE: begin
        if (wait_r == '0) begin
          state_nxt = ST_DRAIN;
        end else begin
          wait_nxt = wait_r - 1'b1;
        end
      end
      ST_DRAIN: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_LOAD;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      wait_r  <= '0;
      ovf_r   <= 1'b0;
      in_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      wait_r  <= wait_nxt;
      ovf_r   <= ovf_nxt;
      in_r    <= in_nxt;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    elem_t cell_in;
    elem_t cell_nbr;
    if (i == 0) begin : g_first
      assign cell_in = in_r;
    end else begin : g_mid
      assign cell_in = pass[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign cell_nbr = '0;
    end else begin : g_inner
      assign cell_nbr = held[i+1];
    end
    ase_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .ins      (cell_in),
      .nbr      (cell_nbr),
      .held     (held[i]),
      .pass     (pass[i])
    );
  end

  assign out_valid        = shift_en;
  assign out_sorted_value = held[0].value;
  assign out_final_result = shift_en && (cnt_r == CNT_W'(1));
  assign out_overflowed   = ovf_r;

  `ASE_ASSERT_IMP(a_out_has_data, out_valid, held[0].valid, "result taken from empty cell")
  `ASE_ASSERT_NXT(a_final_frees, out_final_result, !busy, "block still busy after final result")
  `ASE_ASSERT_NXT(a_last_busy, accept && in_end_of_set, busy, "end of set did not start sort")
  `ASE_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CNT_W'(DEPTH), "element count beyond depth")
  `ASE_ASSERT_IMP(a_drain_cnt, out_valid, cnt_r != '0, "draining with zero count")

endmodule
